>>> design/periodic_event_timer_queue_assert.svh
// assertion macros for the periodic event timer queue
// depends on clk and rst_n being visible in the including module
`ifndef PERIODIC_EVENT_TIMER_QUEUE_ASSERT_SVH
`define PERIODIC_EVENT_TIMER_QUEUE_ASSERT_SVH

// same-cycle implication, quiet while reset is asserted
`define PETQ_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, quiet while reset is asserted
`define PETQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/petq_pkg.sv
// types and constants for the periodic event timer queue
// no dependencies
package petq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int ID_BITS     = 8;
    localparam int TIME_W      = 63;
    localparam int PERIOD_W    = 32;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic [PTR_W:0]    DEPTH_WRAP = (PTR_W + 1)'(QUEUE_DEPTH);
    localparam logic [CNT_W-1:0]  DEPTH_CNT  = CNT_W'(QUEUE_DEPTH);
    localparam logic [TIME_W-1:0] TIME_MAX   = {TIME_W{1'b1}};

    localparam logic MODE_ADD = 1'b0;
    localparam logic MODE_POP = 1'b1;

    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_FULL = 2'd1;
    localparam logic [1:0] STATUS_NONE = 2'd2;

    typedef struct packed {
        logic [TIME_W-1:0]   due_time;
        logic [PERIOD_W-1:0] period;
        logic [ID_BITS-1:0]  id;
    } entry_t;

endpackage

>>> design/periodic_event_timer_queue.sv
// Sequence: an add runs ST_INS_START, then, unless the queue is empty, an insertion pass
// over the entry memory, one entry per cycle from the tail, then ST_FINISH; a pop checks the
// head in ST_POP_CHK, a periodic pop re-inserts it; a dropped add or empty pop goes to ST_FINISH
// Throughput: one item at a time, next item taken once the result is registered.
// Reset: asynchronous, active low; clears the fill count, head pointer and control,
// the entry memory is not cleared.
// top level: sorted event queue kept in a circular memory; depends on petq_pkg
// and periodic_event_timer_queue_assert.svh
`include "periodic_event_timer_queue_assert.svh"

module periodic_event_timer_queue (
    input  logic                          clk,
    input  logic                          rst_n,
    // input item channel
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          mode,
    input  logic [petq_pkg::TIME_W-1:0]   due_time,
    input  logic [petq_pkg::PERIOD_W-1:0] repeat_period,
    input  logic [petq_pkg::ID_BITS-1:0]  event_id,
    input  logic [petq_pkg::TIME_W-1:0]   now_time,
    // result item channel
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          popped_valid,
    output logic [petq_pkg::ID_BITS-1:0]  popped_id,
    output logic [petq_pkg::TIME_W-1:0]   popped_time,
    output logic [petq_pkg::PERIOD_W-1:0] popped_period,
    output logic [1:0]                    status
);

    // sequencer states
    localparam logic [2:0] ST_IDLE      = 3'd0;
    localparam logic [2:0] ST_POP_CHK   = 3'd1;
    localparam logic [2:0] ST_INS_START = 3'd2;
    localparam logic [2:0] ST_INS       = 3'd3;
    localparam logic [2:0] ST_WR_HEAD   = 3'd4;
    localparam logic [2:0] ST_FINISH    = 3'd5;

    // logical queue position to physical memory address, wrapping at the depth
    function automatic logic [petq_pkg::PTR_W-1:0] wrap_addr(
        input logic [petq_pkg::PTR_W-1:0] base,
        input logic [petq_pkg::PTR_W-1:0] offs
    );
        logic [petq_pkg::PTR_W:0] sum;
        sum = {1'b0, base} + {1'b0, offs};
        if (sum >= petq_pkg::DEPTH_WRAP)
        begin
            sum = sum - petq_pkg::DEPTH_WRAP;
        end
        return sum[petq_pkg::PTR_W-1:0];
    endfunction

    // due time advanced by the period, capped at the largest time
    function automatic logic [petq_pkg::TIME_W-1:0] advance_time(
        input logic [petq_pkg::TIME_W-1:0]   t,
        input logic [petq_pkg::PERIOD_W-1:0] p
    );
        logic [petq_pkg::TIME_W:0] sum;
        sum = {1'b0, t} + (petq_pkg::TIME_W + 1)'(p);
        return sum[petq_pkg::TIME_W] ? petq_pkg::TIME_MAX : sum[petq_pkg::TIME_W-1:0];
    endfunction

    // entry memory: one write port, one registered read port
    petq_pkg::entry_t mem [petq_pkg::QUEUE_DEPTH];
    petq_pkg::entry_t rd_data_reg;
    logic [petq_pkg::PTR_W-1:0] rd_addr;
    logic                       wr_en;
    logic [petq_pkg::PTR_W-1:0] wr_addr;
    petq_pkg::entry_t           wr_data;

    // control state
    logic [2:0]                 state_reg, state_next;
    logic [petq_pkg::PTR_W-1:0] head_reg, head_next;
    logic [petq_pkg::CNT_W-1:0] count_reg, count_next;
    logic [petq_pkg::PTR_W-1:0] k_reg, k_next;
    logic                       out_valid_reg, out_valid_next;

    // payload held while an item is in flight
    petq_pkg::entry_t            new_reg, new_next;
    logic [petq_pkg::TIME_W-1:0] now_reg, now_next;
    logic                        res_valid_reg, res_valid_next;
    petq_pkg::entry_t            res_reg, res_next;
    logic [1:0]                  res_status_reg, res_status_next;

    // registered result
    logic                          popped_valid_reg;
    logic [petq_pkg::ID_BITS-1:0]  popped_id_reg;
    logic [petq_pkg::TIME_W-1:0]   popped_time_reg;
    logic [petq_pkg::PERIOD_W-1:0] popped_period_reg;
    logic [1:0]                    status_reg;
    logic                          out_load;

    assign in_stall      = (state_reg != ST_IDLE);
    assign out_valid     = out_valid_reg;
    assign popped_valid  = popped_valid_reg;
    assign popped_id     = popped_id_reg;
    assign popped_time   = popped_time_reg;
    assign popped_period = popped_period_reg;
    assign status        = status_reg;

    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        count_next      = count_reg;
        k_next          = k_reg;
        new_next        = new_reg;
        now_next        = now_reg;
        res_valid_next  = res_valid_reg;
        res_next        = res_reg;
        res_status_next = res_status_reg;
        rd_addr         = head_reg;
        wr_en           = 1'b0;
        wr_addr         = head_reg;
        wr_data         = new_reg;
        out_load        = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                // the head entry is read every idle cycle, so a pop finds it next cycle
                if (in_valid)
                begin
                    res_valid_next  = 1'b0;
                    res_next        = '0;
                    res_status_next = petq_pkg::STATUS_OK;
                    now_next        = now_time;
                    new_next        = '{due_time: due_time, period: repeat_period,
                                        id: event_id};
                    if (mode == petq_pkg::MODE_POP)
                    begin
                        if (count_reg == '0)
                        begin
                            res_status_next = petq_pkg::STATUS_NONE;
                            state_next      = ST_FINISH;
                        end
                        else
                        begin
                            state_next = ST_POP_CHK;
                        end
                    end
                    else if (count_reg == petq_pkg::DEPTH_CNT)
                    begin
                        res_status_next = petq_pkg::STATUS_FULL;
                        state_next      = ST_FINISH;
                    end
                    else
                    begin
                        state_next = ST_INS_START;
                    end
                end
            end

            ST_POP_CHK:
            begin
                // head is due only when strictly earlier than the cutoff
                if (rd_data_reg.due_time < now_reg)
                begin
                    res_valid_next = 1'b1;
                    res_next       = rd_data_reg;
                    head_next      = wrap_addr(head_reg, petq_pkg::PTR_W'(1));
                    count_next     = count_reg - petq_pkg::CNT_W'(1);
                    if (rd_data_reg.period != '0)
                    begin
                        new_next = '{due_time: advance_time(rd_data_reg.due_time,
                                                            rd_data_reg.period),
                                     period: rd_data_reg.period, id: rd_data_reg.id};
                        state_next = ST_INS_START;
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                    end
                end
                else
                begin
                    res_status_next = petq_pkg::STATUS_NONE;
                    state_next      = ST_FINISH;
                end
            end

            ST_INS_START:
            begin
                if (count_reg == '0)
                begin
                    wr_en      = 1'b1;
                    wr_addr    = head_reg;
                    count_next = count_reg + petq_pkg::CNT_W'(1);
                    state_next = ST_FINISH;
                end
                else
                begin
                    // start at the tail entry
                    k_next     = petq_pkg::PTR_W'(count_reg - petq_pkg::CNT_W'(1));
                    rd_addr    = wrap_addr(head_reg, k_next);
                    state_next = ST_INS;
                end
            end

            ST_INS:
            begin
                // rd_data_reg holds entry k; it moves up one place or the new one lands above it
                wr_en   = 1'b1;
                wr_addr = wrap_addr(head_reg, k_reg + petq_pkg::PTR_W'(1));
                if (rd_data_reg.due_time <= new_reg.due_time)
                begin
                    wr_data    = new_reg;
                    count_next = count_reg + petq_pkg::CNT_W'(1);
                    state_next = ST_FINISH;
                end
                else
                begin
                    wr_data = rd_data_reg;
                    if (k_reg == '0)
                    begin
                        state_next = ST_WR_HEAD;
                    end
                    else
                    begin
                        k_next  = k_reg - petq_pkg::PTR_W'(1);
                        rd_addr = wrap_addr(head_reg, k_next);
                    end
                end
            end

            ST_WR_HEAD:
            begin
                // new entry is the earliest of all
                wr_en      = 1'b1;
                wr_addr    = head_reg;
                count_next = count_reg + petq_pkg::CNT_W'(1);
                state_next = ST_FINISH;
            end

            ST_FINISH:
            begin
                // result moves to the output register once it is free
                if (!out_valid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // entry memory
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        new_reg        <= new_next;
        now_reg        <= now_next;
        res_valid_reg  <= res_valid_next;
        res_reg        <= res_next;
        res_status_reg <= res_status_next;
        if (out_load)
        begin
            popped_valid_reg  <= res_valid_next;
            popped_id_reg     <= res_next.id;
            popped_time_reg   <= res_next.due_time;
            popped_period_reg <= res_next.period;
            status_reg        <= res_status_next;
        end
    end

    // checks
    `PETQ_ASSERT_IMPL(a_count_bound, 1'b1, count_reg <= petq_pkg::DEPTH_CNT,
        "entry count above queue depth")
    `PETQ_ASSERT_IMPL(a_ins_index, state_reg == ST_INS, ({1'b0, k_reg} < count_reg),
        "insertion index outside the stored entries")
    `PETQ_ASSERT_NEXT(a_full_drop,
        in_valid && !in_stall && mode == petq_pkg::MODE_ADD &&
        count_reg == petq_pkg::DEPTH_CNT,
        count_reg == petq_pkg::DEPTH_CNT && state_reg == ST_FINISH,
        "add to a full queue changed the count")
    `PETQ_ASSERT_NEXT(a_finish_load,
        state_reg == ST_FINISH && !(out_valid_reg && out_stall),
        out_valid_reg && state_reg == ST_IDLE,
        "finished item not handed to the output register")
    `PETQ_ASSERT_NEXT(a_accept_busy, in_valid && !in_stall, state_reg != ST_IDLE,
        "accepted item did not start work")

endmodule
